### rtl/ttc_pkg.sv
`timescale 1ns / 1ps

package ttc_pkg;

    localparam int DEF_TEXT_COLUMNS = 80;
    localparam int DEF_TEXT_ROWS    = 30;

    localparam int COL_W = 7;
    localparam int ROW_W = 5;
    localparam int IDX_W = 12;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_SETPOS = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One queued action: an optional clear-all, then an optional cell write.
    typedef struct packed {
        logic             clr;
        logic             wr;
        logic [ROW_W-1:0] wrow;
        logic [COL_W-1:0] wcol;
        logic [7:0]       ch;
        logic [15:0]      colour;
    } ttc_act_t;

endpackage

### rtl/ttc_cmd_if.sv
`timescale 1ns / 1ps

interface ttc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [15:0] colour_word;
    logic [7:0]  new_column;
    logic [7:0]  new_row;

    modport source (
        output valid, opcode, char_code, colour_word, new_column, new_row,
        input  ready
    );

    modport sink (
        input  valid, opcode, char_code, colour_word, new_column, new_row,
        output ready
    );
endinterface

### rtl/ttc_cell_if.sv
`timescale 1ns / 1ps

interface ttc_cell_if;
    logic        valid;
    logic        ready;
    logic        clear_all;
    logic [11:0] cell_index;
    logic [7:0]  cell_char;
    logic [15:0] cell_colour;
    logic        last_result;

    modport source (
        output valid, clear_all, cell_index, cell_char, cell_colour, last_result,
        input  ready
    );

    modport sink (
        input  valid, clear_all, cell_index, cell_char, cell_colour, last_result,
        output ready
    );
endinterface

### rtl/ttc_front.sv
`timescale 1ns / 1ps

module ttc_front
    import ttc_pkg::*;
#(
    parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
    parameter int TEXT_ROWS    = DEF_TEXT_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    ttc_cmd_if.sink    cmd,
    input  logic       q_full,
    output logic       push,
    output ttc_act_t   push_act
);

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r1;
    logic             wrap;
    logic             accept;

    assign cmd.ready = !q_full;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        col_next        = col_reg;
        row_next        = row_reg;
        push            = 1'b0;
        push_act.clr    = 1'b0;
        push_act.wr     = 1'b0;
        push_act.wrow   = '0;
        push_act.wcol   = '0;
        push_act.ch     = cmd.char_code;
        push_act.colour = cmd.colour_word;

        // Wrap past the last column, or line feed
        wrap = (col_reg >= COL_W'(TEXT_COLUMNS)) || (cmd.char_code == CH_LF);
        if (wrap && (row_reg < ROW_W'(TEXT_ROWS)))
            r1 = row_reg + ROW_W'(1);
        else
            r1 = row_reg;
        c1 = wrap ? '0 : col_reg;

        case (cmd.opcode)
            OP_SETPOS:
            begin
                col_next = (cmd.new_column > 8'(TEXT_COLUMNS)) ?
                           COL_W'(TEXT_COLUMNS) : cmd.new_column[COL_W-1:0];
                row_next = (cmd.new_row > 8'(TEXT_ROWS)) ?
                           ROW_W'(TEXT_ROWS) : cmd.new_row[ROW_W-1:0];
            end
            OP_CLEAR:
            begin
                col_next     = '0;
                row_next     = '0;
                push         = 1'b1;
                push_act.clr = 1'b1;
                push_act.ch  = CH_SPACE;
            end
            default:
            begin
                if (cmd.char_code == CH_LF)
                begin
                    row_next = r1;
                    col_next = '0;
                end
                else if (r1 >= ROW_W'(TEXT_ROWS))
                begin
                    // Clear, then write the character at the origin
                    push         = 1'b1;
                    push_act.clr = 1'b1;
                    push_act.wr  = 1'b1;
                    row_next     = '0;
                    col_next     = COL_W'(1);
                end
                else if (cmd.char_code == CH_BS)
                begin
                    row_next    = r1;
                    push_act.ch = CH_SPACE;
                    if (c1 != '0)
                    begin
                        col_next      = c1 - COL_W'(1);
                        push          = 1'b1;
                        push_act.wr   = 1'b1;
                        push_act.wrow = r1;
                        push_act.wcol = c1 - COL_W'(1);
                    end
                    else
                    begin
                        col_next = '0;
                        if (r1 != '0)
                        begin
                            // Last cell of the previous row
                            push          = 1'b1;
                            push_act.wr   = 1'b1;
                            push_act.wrow = r1 - ROW_W'(1);
                            push_act.wcol = COL_W'(TEXT_COLUMNS - 1);
                        end
                    end
                end
                else
                begin
                    row_next      = r1;
                    col_next      = c1 + COL_W'(1);
                    push          = 1'b1;
                    push_act.wr   = 1'b1;
                    push_act.wrow = r1;
                    push_act.wcol = c1;
                end
            end
        endcase

        if (!accept)
            push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

### rtl/ttc_fifo.sv
`timescale 1ns / 1ps

module ttc_fifo
    import ttc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ttc_act_t push_act,
    output logic     full,
    output logic     head_valid,
    output ttc_act_t head_act,
    input  logic     pop
);

    ttc_act_t   entries_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_act   = entries_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? !wptr_reg : wptr_reg;
        rptr_next  = pop ? !rptr_reg : rptr_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wptr_reg] <= push_act;
    end

endmodule

### rtl/ttc_back.sv
`timescale 1ns / 1ps

module ttc_back
    import ttc_pkg::*;
#(
    parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  ttc_act_t  head_act,
    output logic      pop,
    ttc_cell_if.source cells
);

    logic             out_valid_reg, out_valid_next;
    logic             phase_reg, phase_next;
    logic             clear_reg, clear_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       char_reg, char_next;
    logic [15:0]      colour_reg, colour_next;
    logic             last_reg, last_next;
    logic             load;

    assign load = !out_valid_reg || cells.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        phase_next     = phase_reg;
        clear_next     = clear_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        colour_next    = colour_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                colour_next = head_act.colour;
                if (head_act.clr && !phase_reg)
                begin
                    clear_next = 1'b1;
                    idx_next   = '0;
                    char_next  = CH_SPACE;
                    last_next  = !head_act.wr;
                    // Hold the entry for its cell write
                    phase_next = head_act.wr;
                    pop        = !head_act.wr;
                end
                else
                begin
                    clear_next = 1'b0;
                    idx_next   = IDX_W'(IDX_W'(head_act.wrow) * IDX_W'(TEXT_COLUMNS)
                                        + IDX_W'(head_act.wcol));
                    char_next  = head_act.ch;
                    last_next  = 1'b1;
                    phase_next = 1'b0;
                    pop        = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clear_reg  <= clear_next;
        idx_reg    <= idx_next;
        char_reg   <= char_next;
        colour_reg <= colour_next;
        last_reg   <= last_next;
    end

    assign cells.valid       = out_valid_reg;
    assign cells.clear_all   = clear_reg;
    assign cells.cell_index  = idx_reg;
    assign cells.cell_char   = char_reg;
    assign cells.cell_colour = colour_reg;
    assign cells.last_result = last_reg;

endmodule

### rtl/text_teletype_cursor.sv
`timescale 1ns / 1ps

// Teletype cursor over a TEXT_COLUMNS x TEXT_ROWS character-cell buffer.
// cmd (sink): put character, set cursor position or clear screen commands.
// cells (source): cell writes and clear-all beats; last_result marks the final
// beat that a command causes. A command may cause zero, one or two beats.
// The front unit keeps the cursor and classifies each command in the cycle it
// is accepted; a two-entry action queue feeds the back unit, which computes
// the linear index and drives a registered output.
// The action for an accepted command is written into a queue entry, then
// loaded into the back unit's output register, which drives cells.
// Throughput: the back unit issues one beat per cycle while the receiver is
// ready; a clear-all followed by a cell write takes two beats from one entry.
// Reset puts the cursor at the origin and empties the queue and output.
// When the receiver stalls, the output beat holds, the queue fills, and
// cmd.ready drops once both queue entries are taken.
module text_teletype_cursor
    import ttc_pkg::*;
#(
    parameter int TEXT_COLUMNS = DEF_TEXT_COLUMNS,
    parameter int TEXT_ROWS    = DEF_TEXT_ROWS
) (
    input  logic       clk,
    input  logic       rst_n,
    ttc_cmd_if.sink    cmd,
    ttc_cell_if.source cells
);

    logic     push;
    ttc_act_t push_act;
    logic     q_full;
    logic     head_valid;
    ttc_act_t head_act;
    logic     pop;

    ttc_front #(
        .TEXT_COLUMNS (TEXT_COLUMNS),
        .TEXT_ROWS    (TEXT_ROWS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .q_full   (q_full),
        .push     (push),
        .push_act (push_act)
    );

    ttc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_act   (push_act),
        .full       (q_full),
        .head_valid (head_valid),
        .head_act   (head_act),
        .pop        (pop)
    );

    ttc_back #(
        .TEXT_COLUMNS (TEXT_COLUMNS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_act   (head_act),
        .pop        (pop),
        .cells      (cells)
    );

endmodule
